// ----- hw/rtl/lgrpf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgrpf_pkg
// Shared types, constants and the intensity log table builder for the lidar
// ground / rotated box point filter.
// ----------------------------------------------------------------------------
package lgrpf_pkg;

   // Point coordinate width and intensity table depth
   localparam int COORD_BITS       = 16;
   localparam int INTENSITY_LEVELS = 256;
   localparam int INT_IDX_BITS     = $clog2(INTENSITY_LEVELS);

   // Q1.14 coefficients, 16 bit config fields
   localparam int CFG_FIELD_BITS = 16;
   localparam int NORM_FRAC_BITS = 14;

   // Datapath widths derived from the coordinate width
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PLANE_PROD_BITS = COORD_BITS + CFG_FIELD_BITS;
   localparam int ROT_PROD_BITS   = DIFF_BITS + CFG_FIELD_BITS;
   localparam int SUM_BITS   = COORD_BITS + 18;

   // Configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 48;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PLANE_NORMAL    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PLANE_OFFSET    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GROUND_MARGIN   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BOX_CENTER      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BOX_HALF_EXTENT = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BOX_ROTATION    = 3'd5;

   localparam logic [47:0] PLANE_NORMAL_RST    = 48'd16384;
   localparam logic [15:0] PLANE_OFFSET_RST    = 16'd0;
   localparam logic [15:0] GROUND_MARGIN_RST   = 16'd20;
   localparam logic [47:0] BOX_CENTER_RST      = 48'd0;
   localparam logic [47:0] BOX_HALF_EXTENT_RST = 48'd0;
   localparam logic [31:0] BOX_ROTATION_RST    = 32'd1073741824;

   // Request and response payloads
   typedef struct packed {
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
      logic signed [COORD_BITS-1:0] point_z;
      logic [7:0]                   raw_intensity;
   } req_payload_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] out_x;
      logic signed [COORD_BITS-1:0] out_y;
      logic signed [COORD_BITS-1:0] out_z;
      logic [15:0]                  log_intensity;
      logic                         keep;
   } rsp_payload_type;

   // Fixed point log2 with LOG_FRAC_BITS fraction bits, truncated; n >= 1.
   // Fraction bits come from repeated squaring of the Q1.30 mantissa.
   localparam int LOG_FRAC_BITS = 24;

   function automatic logic [31:0] log2_fixed(input logic [31:0] n);
      logic [63:0] m;
      logic [31:0] r;
      int          k;
      k = 0;
      for (int j = 0; j < 31; j++) begin
         if ((n >> (j + 1)) != 32'd0) begin
            k = j + 1;
         end
      end
      m = 64'(n) << (30 - k);
      r = 32'(k) << LOG_FRAC_BITS;
      for (int b = 0; b < LOG_FRAC_BITS; b++) begin
         m = (m * m) >> 30;
         if (m >= (64'd2 << 30)) begin
            m = m >> 1;
            r[LOG_FRAC_BITS-1-b] = 1'b1;
         end
      end
      return r;
   endfunction

   localparam logic [31:0] LOG_DEN = log2_fixed(32'(INTENSITY_LEVELS));

   typedef logic [15:0] log_table_type [INTENSITY_LEVELS];

   // q = round_half_up(65535 * log2(1+i) / log2(levels)), saturated
   function automatic log_table_type build_log_table();
      log_table_type t;
      logic [63:0]   num;
      logic [63:0]   q;
      for (int i = 0; i < INTENSITY_LEVELS; i++) begin
         num  = 64'(log2_fixed(32'(i + 1)));
         q    = (64'd65535 * num + 64'(LOG_DEN / 2)) / 64'(LOG_DEN);
         t[i] = (q > 64'd65535) ? 16'hFFFF : q[15:0];
      end
      return t;
   endfunction

endpackage

// ----- hw/rtl/lidar_ground_roi_point_filter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_ground_roi_point_filter_core
// Ground plane removal and rotated box crop for a stream of lidar points,
// with log compression of the return intensity.
// ----------------------------------------------------------------------------
// Pipeline: an accepted request passes through four register stages in order;
// the last one is the output register that drives rsp_valid and rsp_payload.
// Throughput: one request per cycle while rsp_ready is high; set by the four-stage multiply/add pipe.
// Stalls on rsp_ready back up stage by stage; empty stages still fill.
// Reset: synchronous, clears all stage valid bits and loads register defaults
// (unit normal along z, margin 20 cm, zero box, no rotation).
module lidar_ground_roi_point_filter_core
   import lgrpf_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_payload_type           req_payload,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_payload_type           rsp_payload,
   // configuration write port
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam log_table_type LOG_TABLE = build_log_table();

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [47:0] plane_normal_ff;
   logic [15:0] plane_offset_ff;
   logic [15:0] ground_margin_ff;
   logic [47:0] box_center_ff;
   logic [47:0] box_half_extent_ff;
   logic [31:0] box_rotation_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_normal_ff    <= PLANE_NORMAL_RST;
         plane_offset_ff    <= PLANE_OFFSET_RST;
         ground_margin_ff   <= GROUND_MARGIN_RST;
         box_center_ff      <= BOX_CENTER_RST;
         box_half_extent_ff <= BOX_HALF_EXTENT_RST;
         box_rotation_ff    <= BOX_ROTATION_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_PLANE_NORMAL:    plane_normal_ff    <= csr_wdata[47:0];
            CSR_PLANE_OFFSET:    plane_offset_ff    <= csr_wdata[15:0];
            CSR_GROUND_MARGIN:   ground_margin_ff   <= csr_wdata[15:0];
            CSR_BOX_CENTER:      box_center_ff      <= csr_wdata[47:0];
            CSR_BOX_HALF_EXTENT: box_half_extent_ff <= csr_wdata[47:0];
            CSR_BOX_ROTATION:    box_rotation_ff    <= csr_wdata[31:0];
            default: ; // unmapped index: drop the write
         endcase
      end
   end

   // Unpack the register fields
   logic signed [15:0] norm_a, norm_b, norm_c, plane_d;
   logic signed [15:0] ctr_x, ctr_y, ctr_z;
   logic signed [15:0] rot_cos, rot_sin;
   logic [15:0]        half_x, half_y, half_z;

   assign norm_a  = plane_normal_ff[47:32];
   assign norm_b  = plane_normal_ff[31:16];
   assign norm_c  = plane_normal_ff[15:0];
   assign plane_d = plane_offset_ff;
   assign ctr_x   = box_center_ff[47:32];
   assign ctr_y   = box_center_ff[31:16];
   assign ctr_z   = box_center_ff[15:0];
   assign half_x  = box_half_extent_ff[47:32];
   assign half_y  = box_half_extent_ff[31:16];
   assign half_z  = box_half_extent_ff[15:0];
   assign rot_cos = box_rotation_ff[31:16];
   assign rot_sin = box_rotation_ff[15:0];

   // ------------------------------------------------------------------------
   // Pipeline flow control: a stage loads when it is empty or the stage after
   // it is loading too. Valid bits travel with the data.
   // ------------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_ready, s2_ready, s3_ready, s4_ready;

   assign s4_ready  = !s4_valid_ff || rsp_ready;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_ready) begin
            s4_valid_ff <= s3_valid_ff;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1: offsets from the box center and the intensity table lookup
   // ------------------------------------------------------------------------
   logic signed [COORD_BITS-1:0] s1_x_ff, s1_y_ff, s1_z_ff;
   logic signed [DIFF_BITS-1:0]  s1_dx_ff, s1_dx_in;
   logic signed [DIFF_BITS-1:0]  s1_dy_ff, s1_dy_in;
   logic signed [DIFF_BITS-1:0]  s1_dz_ff, s1_dz_in;
   logic [15:0]                  s1_logi_ff, s1_logi_in;
   logic [INT_IDX_BITS-1:0]      int_idx;

   always_comb begin
      s1_dx_in = DIFF_BITS'(req_payload.point_x) - DIFF_BITS'(ctr_x);
      s1_dy_in = DIFF_BITS'(req_payload.point_y) - DIFF_BITS'(ctr_y);
      s1_dz_in = DIFF_BITS'(req_payload.point_z) - DIFF_BITS'(ctr_z);
      // clamp the raw byte to the top table entry
      if (32'(req_payload.raw_intensity) > 32'(INTENSITY_LEVELS - 1)) begin
         int_idx = INT_IDX_BITS'(INTENSITY_LEVELS - 1);
      end else begin
         int_idx = INT_IDX_BITS'(req_payload.raw_intensity);
      end
      s1_logi_in = LOG_TABLE[int_idx];
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_valid) begin
         s1_x_ff    <= req_payload.point_x;
         s1_y_ff    <= req_payload.point_y;
         s1_z_ff    <= req_payload.point_z;
         s1_dx_ff   <= s1_dx_in;
         s1_dy_ff   <= s1_dy_in;
         s1_dz_ff   <= s1_dz_in;
         s1_logi_ff <= s1_logi_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: the seven products, plus the vertical box bound
   // ------------------------------------------------------------------------
   logic signed [PLANE_PROD_BITS-1:0] s2_ax_ff, s2_ax_in;
   logic signed [PLANE_PROD_BITS-1:0] s2_by_ff, s2_by_in;
   logic signed [PLANE_PROD_BITS-1:0] s2_cz_ff, s2_cz_in;
   logic signed [ROT_PROD_BITS-1:0]   s2_cdx_ff, s2_cdx_in;
   logic signed [ROT_PROD_BITS-1:0]   s2_sdy_ff, s2_sdy_in;
   logic signed [ROT_PROD_BITS-1:0]   s2_sdx_ff, s2_sdx_in;
   logic signed [ROT_PROD_BITS-1:0]   s2_cdy_ff, s2_cdy_in;
   logic                              s2_dz_ok_ff, s2_dz_ok_in;
   logic [DIFF_BITS-1:0]              dz_mag;
   logic signed [COORD_BITS-1:0]      s2_x_ff, s2_y_ff, s2_z_ff;
   logic [15:0]                       s2_logi_ff;

   always_comb begin
      s2_ax_in  = norm_a * s1_x_ff;
      s2_by_in  = norm_b * s1_y_ff;
      s2_cz_in  = norm_c * s1_z_ff;
      s2_cdx_in = rot_cos * s1_dx_ff;
      s2_sdy_in = rot_sin * s1_dy_ff;
      s2_sdx_in = rot_sin * s1_dx_ff;
      s2_cdy_in = rot_cos * s1_dy_ff;
      dz_mag    = s1_dz_ff[DIFF_BITS-1] ? DIFF_BITS'(-s1_dz_ff) : DIFF_BITS'(s1_dz_ff);
      s2_dz_ok_in = SUM_BITS'(dz_mag) <= SUM_BITS'(half_z);
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_ax_ff    <= s2_ax_in;
         s2_by_ff    <= s2_by_in;
         s2_cz_ff    <= s2_cz_in;
         s2_cdx_ff   <= s2_cdx_in;
         s2_sdy_ff   <= s2_sdy_in;
         s2_sdx_ff   <= s2_sdx_in;
         s2_cdy_ff   <= s2_cdy_in;
         s2_dz_ok_ff <= s2_dz_ok_in;
         s2_x_ff     <= s1_x_ff;
         s2_y_ff     <= s1_y_ff;
         s2_z_ff     <= s1_z_ff;
         s2_logi_ff  <= s1_logi_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 3: plane distance sum and the rotated local coordinates
   // ------------------------------------------------------------------------
   logic signed [SUM_BITS-1:0]   s3_plane_ff, s3_plane_in;
   logic signed [SUM_BITS-1:0]   s3_lx_ff, s3_lx_in;
   logic signed [SUM_BITS-1:0]   s3_ly_ff, s3_ly_in;
   logic                         s3_dz_ok_ff;
   logic signed [COORD_BITS-1:0] s3_x_ff, s3_y_ff, s3_z_ff;
   logic [15:0]                  s3_logi_ff;

   always_comb begin
      s3_plane_in = SUM_BITS'(s2_ax_ff) + SUM_BITS'(s2_by_ff) + SUM_BITS'(s2_cz_ff)
                  + (SUM_BITS'(plane_d) <<< NORM_FRAC_BITS);
      s3_lx_in    = SUM_BITS'(s2_cdx_ff) - SUM_BITS'(s2_sdy_ff);
      s3_ly_in    = SUM_BITS'(s2_sdx_ff) + SUM_BITS'(s2_cdy_ff);
   end

   always_ff @(posedge clock) begin
      if (s3_ready && s2_valid_ff) begin
         s3_plane_ff <= s3_plane_in;
         s3_lx_ff    <= s3_lx_in;
         s3_ly_ff    <= s3_ly_in;
         s3_dz_ok_ff <= s2_dz_ok_ff;
         s3_x_ff     <= s2_x_ff;
         s3_y_ff     <= s2_y_ff;
         s3_z_ff     <= s2_z_ff;
         s3_logi_ff  <= s2_logi_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 4 (output register): magnitudes against the scaled bounds
   // ------------------------------------------------------------------------
   rsp_payload_type     s4_payload_ff, s4_payload_in;
   logic [SUM_BITS-1:0] plane_mag, lx_mag, ly_mag;
   logic [SUM_BITS-1:0] margin_scaled, hx_scaled, hy_scaled;
   logic                above, in_box;

   always_comb begin
      plane_mag = s3_plane_ff[SUM_BITS-1] ? SUM_BITS'(-s3_plane_ff) : SUM_BITS'(s3_plane_ff);
      lx_mag    = s3_lx_ff[SUM_BITS-1] ? SUM_BITS'(-s3_lx_ff) : SUM_BITS'(s3_lx_ff);
      ly_mag    = s3_ly_ff[SUM_BITS-1] ? SUM_BITS'(-s3_ly_ff) : SUM_BITS'(s3_ly_ff);
      margin_scaled = SUM_BITS'(ground_margin_ff) << NORM_FRAC_BITS;
      hx_scaled     = SUM_BITS'(half_x) << NORM_FRAC_BITS;
      hy_scaled     = SUM_BITS'(half_y) << NORM_FRAC_BITS;
      // strictly above the margin, inclusive on every box bound
      above  = plane_mag > margin_scaled;
      in_box = (lx_mag <= hx_scaled) && (ly_mag <= hy_scaled) && s3_dz_ok_ff;
      s4_payload_in.out_x         = s3_x_ff;
      s4_payload_in.out_y         = s3_y_ff;
      s4_payload_in.out_z         = s3_z_ff;
      s4_payload_in.log_intensity = s3_logi_ff;
      s4_payload_in.keep          = above && in_box;
   end

   always_ff @(posedge clock) begin
      if (s4_ready && s3_valid_ff) begin
         s4_payload_ff <= s4_payload_in;
      end
   end

   assign rsp_valid   = s4_valid_ff;
   assign rsp_payload = s4_payload_ff;

endmodule
